### design/wrsi_pkg.sv
`timescale 1ns / 1ps

package wrsi_pkg;

    // field and state widths
    localparam int PRICE_BITS  = 32;
    localparam int FRAC_BITS   = 16;
    localparam int PERIOD_BITS = 8;
    localparam int COUNT_BITS  = 9;
    localparam int TOTAL_BITS  = 40;
    localparam int RSI_BITS    = 23;

    // averages are Q(PRICE_BITS).(FRAC_BITS)
    localparam int MEAN_BITS = PRICE_BITS + FRAC_BITS;
    // average times a period-sized factor
    localparam int PROD_BITS = MEAN_BITS + PERIOD_BITS;
    // smoothing numerator, product plus new delta
    localparam int NUM_BITS  = PROD_BITS + 1;
    // divider remainder, holds up to gain average plus loss average
    localparam int REM_BITS  = MEAN_BITS + 1;
    localparam int STEP_BITS = 6;

    // quotient bits produced per division
    localparam logic [STEP_BITS-1:0] MEAN_STEPS  = STEP_BITS'(MEAN_BITS);
    localparam logic [STEP_BITS-1:0] RATIO_STEPS = STEP_BITS'(RSI_BITS);
    localparam int RATIO_SHIFT = RSI_BITS - FRAC_BITS;

    localparam logic [COUNT_BITS-1:0]  COUNT_MAX      = '1;
    localparam logic [PERIOD_BITS-1:0] PERIOD_RESET   = PERIOD_BITS'(14);
    localparam logic [PERIOD_BITS-1:0] PERCENT_SCALE  = PERIOD_BITS'(100);
    localparam logic [RSI_BITS-1:0]    RSI_HALF       = RSI_BITS'(50 << FRAC_BITS);
    localparam logic [RSI_BITS-1:0]    RSI_FULL       = RSI_BITS'(100 << FRAC_BITS);

    localparam logic OP_UPDATE  = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    // request to the shared divider
    typedef struct packed {
        logic                 start;
        logic [REM_BITS-1:0]  rem_init;
        logic [MEAN_BITS-1:0] low_bits;
        logic [REM_BITS-1:0]  divisor;
        logic [STEP_BITS-1:0] steps;
    } div_cmd_t;

    // divider status
    typedef struct packed {
        logic                 done;
        logic [MEAN_BITS-1:0] quotient;
    } div_stat_t;

endpackage

### design/wrsi_sample_if.sv
`timescale 1ns / 1ps

interface wrsi_sample_if;
    import wrsi_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  opcode;
    logic [PRICE_BITS-1:0] price;

    modport source (output valid, output opcode, output price, input ready);
    modport sink   (input valid, input opcode, input price, output ready);
endinterface

### design/wrsi_result_if.sv
`timescale 1ns / 1ps

interface wrsi_result_if;
    import wrsi_pkg::*;

    logic                valid;
    logic                ready;
    logic [RSI_BITS-1:0] rsi_value;
    logic                warmed_up;

    modport source (output valid, output rsi_value, output warmed_up, input ready);
    modport sink   (input valid, input rsi_value, input warmed_up, output ready);
endinterface

### design/wrsi_cfg_if.sv
`timescale 1ns / 1ps

interface wrsi_cfg_if;
    import wrsi_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [PERIOD_BITS-1:0] period;

    modport source (output valid, output period, input ready);
    modport sink   (input valid, input period, output ready);
endinterface

### design/wrsi_divider.sv
`timescale 1ns / 1ps

module wrsi_divider (
    input  logic                clk,
    input  logic                rst_n,
    input  wrsi_pkg::div_cmd_t  cmd,
    output wrsi_pkg::div_stat_t stat
);
    import wrsi_pkg::*;

    logic [STEP_BITS-1:0] count_reg;
    logic [STEP_BITS-1:0] count_next;
    logic                 done_reg;
    logic                 done_next;
    logic [REM_BITS-1:0]  rem_reg;
    logic [REM_BITS-1:0]  rem_next;
    logic [MEAN_BITS-1:0] low_reg;
    logic [MEAN_BITS-1:0] low_next;
    logic [REM_BITS-1:0]  div_reg;
    logic [MEAN_BITS-1:0] quot_reg;
    logic [MEAN_BITS-1:0] quot_next;
    logic [REM_BITS+1:0]  diff;
    logic                 fits;
    logic                 busy;

    assign busy = (count_reg != '0);

    // one restoring step: bring down next dividend bit, trial subtract
    assign diff = {1'b0, rem_reg, low_reg[MEAN_BITS-1]} - {2'b00, div_reg};
    assign fits = ~diff[REM_BITS+1];

    always_comb
    begin
        count_next = count_reg;
        done_next  = 1'b0;
        rem_next   = rem_reg;
        low_next   = low_reg;
        quot_next  = quot_reg;
        if (cmd.start)
        begin
            count_next = cmd.steps;
            rem_next   = cmd.rem_init;
            low_next   = cmd.low_bits;
            quot_next  = '0;
        end
        else if (busy)
        begin
            count_next = count_reg - 1'b1;
            done_next  = (count_reg == STEP_BITS'(1));
            rem_next   = fits ? diff[REM_BITS-1:0] : {rem_reg[REM_BITS-2:0], low_reg[MEAN_BITS-1]};
            low_next   = {low_reg[MEAN_BITS-2:0], 1'b0};
            quot_next  = {quot_reg[MEAN_BITS-2:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        low_reg  <= low_next;
        quot_reg <= quot_next;
        if (cmd.start)
        begin
            div_reg <= cmd.divisor;
        end
    end

    assign stat.done     = done_reg;
    assign stat.quotient = quot_reg;

    // a new division only starts on an idle unit
    assert property (@(posedge clk) disable iff (!rst_n) cmd.start |-> !busy)
        else $error("divider restarted while busy");

    // done pulses in the cycle after the last step
    assert property (@(posedge clk) disable iff (!rst_n)
        (busy && count_reg == STEP_BITS'(1) && !cmd.start) |=> (done_reg && !busy))
        else $error("divider done pulse missing");

    // remainder is below the divisor when the division is done
    assert property (@(posedge clk) disable iff (!rst_n) done_reg |-> (rem_reg < div_reg))
        else $error("divider remainder out of range");

endmodule

### design/wilder_rsi_indicator.sv
`timescale 1ns / 1ps

// channel   role    handshake        payload
// sample    sink    valid / ready    opcode, price
// result    source  valid / ready    rsi_value, warmed_up
// cfg       sink    valid / ready    period (ready always high)
//
// restart, first price and warm-up requests go from idle straight to the done state
// a smoothing request runs the multiply steps, then the gain and loss average divisions
// and the ratio division; the one closing the warm-up skips the three multiply steps,
// and a zero loss average skips the ratio division; one radix-2 divider does the gain
// average, the loss average and the ratio in turn, one bit a cycle
// sample.ready is high only when the sequencer is idle
// a finished result sits in the output register while the next request is taken
// rst_n clears all history and loads period 14 and rsi 50 percent

module wilder_rsi_indicator (
    input  logic                clk,
    input  logic                rst_n,
    wrsi_sample_if.sink         sample,
    wrsi_result_if.source       result,
    wrsi_cfg_if.sink            cfg
);
    import wrsi_pkg::*;

    // sequencer states, one-hot
    typedef enum logic [11:0] {
        S_IDLE      = 12'b0000_0000_0001,
        S_MUL_G     = 12'b0000_0000_0010,
        S_MUL_L     = 12'b0000_0000_0100,
        S_SUM_L     = 12'b0000_0000_1000,
        S_DIV_G     = 12'b0000_0001_0000,
        S_WAIT_G    = 12'b0000_0010_0000,
        S_DIV_L     = 12'b0000_0100_0000,
        S_WAIT_L    = 12'b0000_1000_0000,
        S_RATIO_MUL = 12'b0001_0000_0000,
        S_RATIO_DIV = 12'b0010_0000_0000,
        S_WAIT_R    = 12'b0100_0000_0000,
        S_DONE      = 12'b1000_0000_0000
    } state_t;

    state_t                 state_reg;
    state_t                 state_next;

    // configuration
    logic [PERIOD_BITS-1:0] period_reg;
    logic [PERIOD_BITS-1:0] p_eff;
    logic [PERIOD_BITS-1:0] p_less1;
    logic [COUNT_BITS-1:0]  p_plus1;

    // indicator history
    logic [PRICE_BITS-1:0]  last_price_reg;
    logic [PRICE_BITS-1:0]  last_price_next;
    logic [COUNT_BITS-1:0]  count_reg;
    logic [COUNT_BITS-1:0]  count_next;
    logic [COUNT_BITS-1:0]  count_inc;
    logic [TOTAL_BITS-1:0]  gain_total_reg;
    logic [TOTAL_BITS-1:0]  gain_total_next;
    logic [TOTAL_BITS-1:0]  loss_total_reg;
    logic [TOTAL_BITS-1:0]  loss_total_next;
    logic [MEAN_BITS-1:0]   mean_gain_reg;
    logic [MEAN_BITS-1:0]   mean_gain_next;
    logic [MEAN_BITS-1:0]   mean_loss_reg;
    logic [MEAN_BITS-1:0]   mean_loss_next;
    logic [RSI_BITS-1:0]    held_rsi_reg;
    logic [RSI_BITS-1:0]    held_rsi_next;
    logic                   warm_reg;
    logic                   warm_next;

    // working registers of one request
    logic [PRICE_BITS-1:0]  gain_reg;
    logic [PRICE_BITS-1:0]  gain_next;
    logic [PRICE_BITS-1:0]  loss_reg;
    logic [PRICE_BITS-1:0]  loss_next;
    logic [PROD_BITS-1:0]   prod_reg;
    logic [PROD_BITS-1:0]   prod_next;
    logic [NUM_BITS-1:0]    num_g_reg;
    logic [NUM_BITS-1:0]    num_g_next;
    logic [NUM_BITS-1:0]    num_l_reg;
    logic [NUM_BITS-1:0]    num_l_next;
    logic [REM_BITS-1:0]    sum_reg;
    logic [REM_BITS-1:0]    sum_next;

    // output register
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [RSI_BITS-1:0]    out_rsi_reg;
    logic [RSI_BITS-1:0]    out_rsi_next;
    logic                   out_warm_reg;
    logic                   out_warm_next;

    // shared multiplier and divider
    logic [MEAN_BITS-1:0]   mul_a;
    logic [PERIOD_BITS-1:0] mul_b;
    logic [PROD_BITS-1:0]   mul_p;
    div_cmd_t               div_cmd;
    div_stat_t              div_stat;

    logic                   accept;
    logic                   out_free;

    assign accept   = sample.valid && sample.ready;
    assign out_free = !out_valid_reg || result.ready;

    // period zero behaves as period one
    assign p_eff   = (period_reg == '0) ? PERIOD_BITS'(1) : period_reg;
    assign p_less1 = p_eff - 1'b1;
    assign p_plus1 = {1'b0, p_eff} + 1'b1;

    // sample counter saturates
    assign count_inc = (count_reg == COUNT_MAX) ? count_reg : count_reg + 1'b1;

    // one multiplier: average times (period-1), or gain average times 100
    always_comb
    begin
        mul_a = mean_gain_reg;
        mul_b = p_less1;
        case (state_reg)
            S_MUL_L:     mul_a = mean_loss_reg;
            S_RATIO_MUL: mul_b = PERCENT_SCALE;
            default:     mul_a = mean_gain_reg;
        endcase
    end

    assign mul_p = PROD_BITS'(mul_a) * PROD_BITS'(mul_b);

    // divider requests: averages over period, then the scaled ratio
    always_comb
    begin
        div_cmd          = '0;
        div_cmd.divisor  = REM_BITS'(p_eff);
        div_cmd.steps    = MEAN_STEPS;
        div_cmd.rem_init = REM_BITS'(num_g_reg >> MEAN_BITS);
        div_cmd.low_bits = num_g_reg[MEAN_BITS-1:0];
        case (state_reg)
            S_DIV_G:
            begin
                div_cmd.start = 1'b1;
            end
            S_DIV_L:
            begin
                div_cmd.start    = 1'b1;
                div_cmd.rem_init = REM_BITS'(num_l_reg >> MEAN_BITS);
                div_cmd.low_bits = num_l_reg[MEAN_BITS-1:0];
            end
            S_RATIO_DIV:
            begin
                // dividend is gain average * 100 << frac, top part seeds the remainder
                div_cmd.start    = 1'b1;
                div_cmd.divisor  = sum_reg;
                div_cmd.steps    = RATIO_STEPS;
                div_cmd.rem_init = REM_BITS'(prod_reg >> RATIO_SHIFT);
                div_cmd.low_bits = MEAN_BITS'({prod_reg[RATIO_SHIFT-1:0], {FRAC_BITS{1'b0}}})
                                   << (MEAN_BITS - RSI_BITS);
            end
            default:
            begin
                div_cmd.start = 1'b0;
            end
        endcase
    end

    wrsi_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (div_cmd),
        .stat  (div_stat)
    );

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        last_price_next = last_price_reg;
        count_next      = count_reg;
        gain_total_next = gain_total_reg;
        loss_total_next = loss_total_reg;
        mean_gain_next  = mean_gain_reg;
        mean_loss_next  = mean_loss_reg;
        held_rsi_next   = held_rsi_reg;
        warm_next       = warm_reg;
        gain_next       = gain_reg;
        loss_next       = loss_reg;
        prod_next       = prod_reg;
        num_g_next      = num_g_reg;
        num_l_next      = num_l_reg;
        sum_next        = sum_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        out_rsi_next    = out_rsi_reg;
        out_warm_next   = out_warm_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_DONE;
                    if (sample.opcode == OP_RESTART)
                    begin
                        last_price_next = '0;
                        count_next      = '0;
                        gain_total_next = '0;
                        loss_total_next = '0;
                        mean_gain_next  = '0;
                        mean_loss_next  = '0;
                        held_rsi_next   = RSI_HALF;
                        warm_next       = 1'b0;
                    end
                    else
                    begin
                        count_next      = count_inc;
                        last_price_next = sample.price;
                        warm_next       = (count_inc >= p_plus1);
                        gain_next = (sample.price > last_price_reg) ?
                                    sample.price - last_price_reg : '0;
                        loss_next = (sample.price < last_price_reg) ?
                                    last_price_reg - sample.price : '0;
                        if (count_inc == COUNT_BITS'(1))
                        begin
                            // first price after restart
                            held_rsi_next = RSI_HALF;
                        end
                        else if (count_inc <= p_plus1)
                        begin
                            // warm-up: accumulate deltas
                            gain_total_next = gain_total_reg + TOTAL_BITS'(gain_next);
                            loss_total_next = loss_total_reg + TOTAL_BITS'(loss_next);
                            if (count_inc == p_plus1)
                            begin
                                num_g_next = NUM_BITS'({gain_total_next, {FRAC_BITS{1'b0}}});
                                num_l_next = NUM_BITS'({loss_total_next, {FRAC_BITS{1'b0}}});
                                state_next = S_DIV_G;
                            end
                            else
                            begin
                                held_rsi_next = RSI_HALF;
                            end
                        end
                        else
                        begin
                            state_next = S_MUL_G;
                        end
                    end
                end
            end
            S_MUL_G:
            begin
                prod_next  = mul_p;
                state_next = S_MUL_L;
            end
            S_MUL_L:
            begin
                num_g_next = NUM_BITS'(prod_reg) + NUM_BITS'({gain_reg, {FRAC_BITS{1'b0}}});
                prod_next  = mul_p;
                state_next = S_SUM_L;
            end
            S_SUM_L:
            begin
                num_l_next = NUM_BITS'(prod_reg) + NUM_BITS'({loss_reg, {FRAC_BITS{1'b0}}});
                state_next = S_DIV_G;
            end
            S_DIV_G:
            begin
                state_next = S_WAIT_G;
            end
            S_WAIT_G:
            begin
                if (div_stat.done)
                begin
                    mean_gain_next = div_stat.quotient;
                    state_next     = S_DIV_L;
                end
            end
            S_DIV_L:
            begin
                state_next = S_WAIT_L;
            end
            S_WAIT_L:
            begin
                if (div_stat.done)
                begin
                    mean_loss_next = div_stat.quotient;
                    state_next     = S_RATIO_MUL;
                end
            end
            S_RATIO_MUL:
            begin
                if (mean_loss_reg == '0)
                begin
                    held_rsi_next = RSI_FULL;
                    state_next    = S_DONE;
                end
                else
                begin
                    prod_next  = mul_p;
                    sum_next   = REM_BITS'(mean_gain_reg) + REM_BITS'(mean_loss_reg);
                    state_next = S_RATIO_DIV;
                end
            end
            S_RATIO_DIV:
            begin
                state_next = S_WAIT_R;
            end
            S_WAIT_R:
            begin
                if (div_stat.done)
                begin
                    held_rsi_next = div_stat.quotient[RSI_BITS-1:0];
                    state_next    = S_DONE;
                end
            end
            S_DONE:
            begin
                // hand over once the output register is free
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_rsi_next   = held_rsi_reg;
                    out_warm_next  = warm_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            period_reg     <= PERIOD_RESET;
            last_price_reg <= '0;
            count_reg      <= '0;
            gain_total_reg <= '0;
            loss_total_reg <= '0;
            mean_gain_reg  <= '0;
            mean_loss_reg  <= '0;
            held_rsi_reg   <= RSI_HALF;
            warm_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            last_price_reg <= last_price_next;
            count_reg      <= count_next;
            gain_total_reg <= gain_total_next;
            loss_total_reg <= loss_total_next;
            mean_gain_reg  <= mean_gain_next;
            mean_loss_reg  <= mean_loss_next;
            held_rsi_reg   <= held_rsi_next;
            warm_reg       <= warm_next;
            out_valid_reg  <= out_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                period_reg <= cfg.period;
            end
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        gain_reg    <= gain_next;
        loss_reg    <= loss_next;
        prod_reg    <= prod_next;
        num_g_reg   <= num_g_next;
        num_l_reg   <= num_l_next;
        sum_reg     <= sum_next;
        out_rsi_reg <= out_rsi_next;
        out_warm_reg <= out_warm_next;
    end

    assign sample.ready     = (state_reg == S_IDLE);
    assign cfg.ready        = 1'b1;
    assign result.valid     = out_valid_reg;
    assign result.rsi_value = out_rsi_reg;
    assign result.warmed_up = out_warm_reg;

    // divider only answers while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == S_WAIT_G || state_reg == S_WAIT_L ||
                           state_reg == S_WAIT_R))
        else $error("divider result with no waiting step");

    // rsi never exceeds 100 percent
    assert property (@(posedge clk) disable iff (!rst_n) held_rsi_reg <= RSI_FULL)
        else $error("rsi above full scale");

    // a taken request always leaves idle
    assert property (@(posedge clk) disable iff (!rst_n) accept |=> (state_reg != S_IDLE))
        else $error("request taken but sequencer stayed idle");

    // a result is only loaded when the output register is free
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && !out_free) |=> (state_reg == S_DONE && out_valid_reg))
        else $error("result overwrote a pending one");

endmodule

### bench/wilder_rsi_indicator_tb.sv
`timescale 1ns / 1ps

module wilder_rsi_indicator_tb;
    import wrsi_pkg::*;

    // run limits
    localparam int CYCLE_LIMIT = 1000000;
    localparam int END_WAIT    = 150;
    localparam int CFG_SETTLE  = 4;
    localparam int PRINT_LIMIT = 40;

    // kinds of row in the directed plan
    localparam logic ROW_ITEM = 1'b0;
    localparam logic ROW_CFG  = 1'b1;

    // one row of stimulus: a price request, or a period write carried in price
    typedef struct packed {
        logic                  kind;
        logic                  op;
        logic [PRICE_BITS-1:0] price;
        logic                  typed;
        logic [RSI_BITS-1:0]   rsi;
        logic                  warm;
    } request_t;

    // one expected answer
    typedef struct packed {
        logic [RSI_BITS-1:0] rsi;
        logic                warm;
    } rsi_result_t;

    // directed plan: reset period first, then period 1, period 0, period 255 and period 2
    // the answer is typed in where it is obvious, otherwise the predictor decides
    localparam request_t DIRECTED_PLAN [0:27] = '{
        '{ROW_ITEM, OP_UPDATE,  32'h0000_0000, 1'b1, RSI_HALF, 1'b0},
        '{ROW_ITEM, OP_UPDATE,  32'hFFFF_FFFF, 1'b1, RSI_HALF, 1'b0},
        '{ROW_ITEM, OP_RESTART, 32'hFFFF_FFFF, 1'b1, RSI_HALF, 1'b0},
        '{ROW_CFG,  OP_UPDATE,  32'd1,         1'b0, '0,       1'b0},
        '{ROW_ITEM, OP_UPDATE,  32'd100,       1'b1, RSI_HALF, 1'b0},
        '{ROW_ITEM, OP_UPDATE,  32'd200,       1'b1, RSI_FULL, 1'b1},
        '{ROW_ITEM, OP_UPDATE,  32'd200,       1'b1, RSI_FULL, 1'b1},
        '{ROW_ITEM, OP_UPDATE,  32'd0,         1'b1, '0,       1'b1},
        '{ROW_ITEM, OP_UPDATE,  32'hFFFF_FFFF, 1'b1, RSI_FULL, 1'b1},
        '{ROW_ITEM, OP_UPDATE,  32'd0,         1'b1, '0,       1'b1},
        '{ROW_ITEM, OP_UPDATE,  32'h8000_0000, 1'b0, '0,       1'b0},
        '{ROW_CFG,  OP_UPDATE,  32'd0,         1'b0, '0,       1'b0},
        '{ROW_ITEM, OP_RESTART, 32'd0,         1'b1, RSI_HALF, 1'b0},
        '{ROW_ITEM, OP_UPDATE,  32'd5,         1'b1, RSI_HALF, 1'b0},
        '{ROW_ITEM, OP_UPDATE,  32'd3,         1'b1, '0,       1'b1},
        '{ROW_ITEM, OP_UPDATE,  32'd7,         1'b1, RSI_FULL, 1'b1},
        '{ROW_CFG,  OP_UPDATE,  32'd255,       1'b0, '0,       1'b0},
        '{ROW_ITEM, OP_RESTART, 32'h5A5A_A5A5, 1'b1, RSI_HALF, 1'b0},
        '{ROW_ITEM, OP_UPDATE,  32'hFFFF_FFFF, 1'b1, RSI_HALF, 1'b0},
        '{ROW_ITEM, OP_UPDATE,  32'd0,         1'b1, RSI_HALF, 1'b0},
        '{ROW_ITEM, OP_UPDATE,  32'h1234_5678, 1'b1, RSI_HALF, 1'b0},
        '{ROW_CFG,  OP_UPDATE,  32'd2,         1'b0, '0,       1'b0},
        '{ROW_ITEM, OP_RESTART, 32'd0,         1'b1, RSI_HALF, 1'b0},
        '{ROW_ITEM, OP_UPDATE,  32'd10,        1'b1, RSI_HALF, 1'b0},
        '{ROW_ITEM, OP_UPDATE,  32'd20,        1'b1, RSI_HALF, 1'b0},
        '{ROW_ITEM, OP_UPDATE,  32'd15,        1'b0, '0,       1'b0},
        '{ROW_ITEM, OP_UPDATE,  32'd15,        1'b0, '0,       1'b0},
        '{ROW_ITEM, OP_UPDATE,  32'd25,        1'b0, '0,       1'b0}
    };

    // random segments: period, length, restart chance in percent
    // the last one runs long enough at period 255 to saturate the sample counter
    localparam int SEGMENTS = 6;
    localparam int SEG_PERIOD  [0:SEGMENTS-1] = '{3, 0, 1, 14, 7, 255};
    localparam int SEG_LEN     [0:SEGMENTS-1] = '{100, 40, 60, 100, 60, 560};
    localparam int SEG_RESTART [0:SEGMENTS-1] = '{3, 5, 3, 2, 4, 0};

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // request side, driven only with nonblocking assignments at the rising edge
    logic                   src_valid  = 1'b0;
    logic                   src_opcode = OP_UPDATE;
    logic [PRICE_BITS-1:0]  src_price  = '0;
    logic                   sink_ready = 1'b0;
    logic                   cfg_valid  = 1'b0;
    logic [PERIOD_BITS-1:0] cfg_period = '0;

    // idling, in percent of cycles
    int unsigned src_gap_pct    = 0;
    int unsigned sink_stall_pct = 0;

    int unsigned cycle_count = 0;
    int unsigned mismatches  = 0;

    // answers still owed by the block, oldest first
    rsi_result_t rsi_pending [$];
    rsi_result_t rsi_head;

    // predictor state
    logic [PERIOD_BITS-1:0] held_period;
    logic [PRICE_BITS-1:0]  prev_px;
    logic [COUNT_BITS-1:0]  px_count;
    logic [TOTAL_BITS-1:0]  up_sum;
    logic [TOTAL_BITS-1:0]  down_sum;
    logic [MEAN_BITS-1:0]   up_avg;
    logic [MEAN_BITS-1:0]   down_avg;
    logic [RSI_BITS-1:0]    held_rsi;

    wrsi_sample_if sample_bus ();
    wrsi_result_if result_bus ();
    wrsi_cfg_if    cfg_bus ();

    assign sample_bus.valid  = src_valid;
    assign sample_bus.opcode = src_opcode;
    assign sample_bus.price  = src_price;
    assign result_bus.ready  = sink_ready;
    assign cfg_bus.valid     = cfg_valid;
    assign cfg_bus.period    = cfg_period;

    wilder_rsi_indicator uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_bus),
        .result (result_bus),
        .cfg    (cfg_bus)
    );

    always #5 clk = ~clk;

    // wipe the price history, the period register is kept
    function automatic void clear_history();
        prev_px  = '0;
        px_count = '0;
        up_sum   = '0;
        down_sum = '0;
        up_avg   = '0;
        down_avg = '0;
        held_rsi = RSI_HALF;
    endfunction

    // exact floor of 100 percent times gain over gain plus loss, or 100 with no loss
    function automatic void refresh_rsi();
        logic [127:0] num;
        if (down_avg == '0)
        begin
            held_rsi = RSI_FULL;
        end
        else
        begin
            num = 128'(RSI_FULL) * 128'(up_avg);
            held_rsi = RSI_BITS'(num / (128'(up_avg) + 128'(down_avg)));
        end
    endfunction

    // advance the predicted indicator by one request and return its answer
    function automatic rsi_result_t rsi_step(input logic op, input logic [PRICE_BITS-1:0] px);
        logic [63:0] p;
        logic [63:0] up;
        logic [63:0] down;
        rsi_result_t r;
        // a period of zero behaves as one
        p = (held_period == '0) ? 64'd1 : 64'(held_period);
        r.warm = 1'b0;
        if (op == OP_RESTART)
        begin
            clear_history();
        end
        else
        begin
            // counter sticks at its top value
            if (px_count < COUNT_MAX)
                px_count = px_count + 1'b1;
            if (px_count == 1)
            begin
                // first price only sets the reference
                prev_px  = px;
                held_rsi = RSI_HALF;
            end
            else
            begin
                up   = (px > prev_px) ? 64'(px - prev_px) : 64'd0;
                down = (px < prev_px) ? 64'(prev_px - px) : 64'd0;
                prev_px = px;
                if (64'(px_count) <= p + 1)
                begin
                    // warm-up: plain sums, the last delta turns them into averages
                    up_sum   = up_sum + TOTAL_BITS'(up);
                    down_sum = down_sum + TOTAL_BITS'(down);
                    if (64'(px_count) == p + 1)
                    begin
                        up_avg   = MEAN_BITS'((64'(up_sum) << FRAC_BITS) / p);
                        down_avg = MEAN_BITS'((64'(down_sum) << FRAC_BITS) / p);
                        refresh_rsi();
                    end
                    else
                    begin
                        held_rsi = RSI_HALF;
                    end
                end
                else
                begin
                    // wilder smoothing with truncating division
                    up_avg   = MEAN_BITS'((64'(up_avg) * (p - 1) + (up << FRAC_BITS)) / p);
                    down_avg = MEAN_BITS'((64'(down_avg) * (p - 1) + (down << FRAC_BITS)) / p);
                    refresh_rsi();
                end
            end
            r.warm = (64'(px_count) >= p + 1);
        end
        r.rsi = held_rsi;
        return r;
    endfunction

    // mostly small moves around the last price, now and then extremes and jumps
    function automatic logic [PRICE_BITS-1:0] next_price(input logic [PRICE_BITS-1:0] prev);
        int unsigned pick;
        logic [PRICE_BITS-1:0] step;
        pick = $urandom_range(0, 19);
        step = (pick < 14) ? $urandom_range(0, 4000) : $urandom_range(0, 32'h00FF_FFFF);
        case (pick)
            0:       return '0;
            1:       return '1;
            2, 3:    return $urandom();
            4:       return prev;
            5:       return prev ^ (32'd1 << $urandom_range(0, 31));
            default: return $urandom_range(0, 1) ? prev + step : prev - step;
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < PRINT_LIMIT)
            $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // present one request, wait for its handshake, then log what it should answer
    // valid is left high so a back-to-back request does not drop it
    task automatic send_request(input request_t req);
        rsi_result_t ans;
        while ($urandom_range(0, 99) < src_gap_pct)
        begin
            src_valid <= 1'b0;
            @(posedge clk);
        end
        src_valid  <= 1'b1;
        src_opcode <= req.op;
        src_price  <= req.price;
        @(posedge clk);
        while (!sample_bus.ready)
            @(posedge clk);
        ans = rsi_step(req.op, req.price);
        if (req.typed)
        begin
            ans.rsi  = req.rsi;
            ans.warm = req.warm;
        end
        rsi_pending.push_back(ans);
    endtask

    // hold off the sender until every owed answer has come back
    task automatic drain_requests();
        src_valid <= 1'b0;
        @(posedge clk);
        while (rsi_pending.size() != 0)
            @(posedge clk);
    endtask

    // change the period only with the block idle
    task automatic write_period(input logic [PERIOD_BITS-1:0] value);
        drain_requests();
        repeat (CFG_SETTLE) @(posedge clk);
        cfg_valid  <= 1'b1;
        cfg_period <= value;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
        held_period = value;
        cfg_valid <= 1'b0;
    endtask

    // answer side: compare every accepted answer with the oldest owed one
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_bus.valid && sink_ready)
            begin
                if (rsi_pending.size() == 0)
                begin
                    report_mismatch($sformatf("answer rsi %0d warm %0d with no request owed",
                                              result_bus.rsi_value, result_bus.warmed_up));
                end
                else
                begin
                    rsi_head = rsi_pending.pop_front();
                    if (result_bus.rsi_value !== rsi_head.rsi)
                        report_mismatch($sformatf("rsi_value got %0d, wanted %0d",
                                                  result_bus.rsi_value, rsi_head.rsi));
                    if (result_bus.warmed_up !== rsi_head.warm)
                        report_mismatch($sformatf("warmed_up got %0d, wanted %0d",
                                                  result_bus.warmed_up, rsi_head.warm));
                end
            end
            sink_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timed out after %0d cycles, %0d answers owed",
                     cycle_count, rsi_pending.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        request_t req;
        logic [PRICE_BITS-1:0] walk_px;
        int unsigned rnd_count;
        held_period = PERIOD_RESET;
        clear_history();
        walk_px   = $urandom();
        rnd_count = 0;

        // hold reset at the start, once
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part with sender idling lightly and receiver heavily
        src_gap_pct    = 9;
        sink_stall_pct = 54;
        foreach (DIRECTED_PLAN[i])
        begin
            if (DIRECTED_PLAN[i].kind == ROW_CFG)
                write_period(PERIOD_BITS'(DIRECTED_PLAN[i].price));
            else
                send_request(DIRECTED_PLAN[i]);
        end

        // random part, each segment opens with a period write and a restart
        for (int s = 0; s < SEGMENTS; s++)
        begin
            write_period(PERIOD_BITS'(SEG_PERIOD[s]));
            for (int k = 0; k < SEG_LEN[s]; k++)
            begin
                // idling swaps sides after a third of the run, and stops after two
                if (rnd_count < 300)
                begin
                    src_gap_pct    = 9;
                    sink_stall_pct = 54;
                end
                else if (rnd_count < 600)
                begin
                    src_gap_pct    = 54;
                    sink_stall_pct = 9;
                end
                else
                begin
                    src_gap_pct    = 0;
                    sink_stall_pct = 0;
                end
                // now and then let the pipeline run dry before the next request
                if ($urandom_range(0, 99) == 0)
                    drain_requests();
                req.kind  = ROW_ITEM;
                req.typed = 1'b0;
                req.rsi   = '0;
                req.warm  = 1'b0;
                if (k == 0 || $urandom_range(0, 99) < SEG_RESTART[s])
                begin
                    // price is don't-care on restart, so keep it noisy
                    req.op    = OP_RESTART;
                    req.price = $urandom();
                end
                else
                begin
                    req.op    = OP_UPDATE;
                    req.price = next_price(walk_px);
                    walk_px   = req.price;
                end
                send_request(req);
                rnd_count++;
            end
        end

        // wait for the last answers, then give the block time to show anything stray
        drain_requests();
        repeat (END_WAIT) @(posedge clk);
        if (rsi_pending.size() != 0)
            report_mismatch($sformatf("%0d answers never arrived", rsi_pending.size()));
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
